### hw/rtl/ppd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_pkg: shared types and constants of the particle push and deposit engine
// fixed point formats, grid geometry, operation codes, job and config records
// ----------------------------------------------------------------------------
package ppd_pkg;

    // grid and number formats
    localparam int GRID_SIZE  = 64;
    localparam int AXIS_W     = 6;                 // bits of one cell coordinate
    localparam int FRAC_BITS  = 16;
    localparam int CELL_W     = 3 * AXIS_W;        // cell index, x major
    localparam int NCELLS     = 2 ** CELL_W;
    localparam int POS_W      = AXIS_W + FRAC_BITS;
    localparam int FLD_W      = 32;
    localparam int SPD_W      = 32;
    localparam int CHG_W      = 40;
    localparam int GAIN_W     = 24;
    localparam int WGT_W      = FRAC_BITS + 1;     // weight, up to one inclusive
    localparam int CORNERS    = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W  = 2;

    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_BITS;

    // register reset values
    localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST    = GAIN_W'(26214);
    localparam logic [GAIN_W-1:0] DRIFT_GAIN_RST    = GAIN_W'(83886);
    localparam logic [GAIN_W-1:0] CHARGE_AMOUNT_RST = GAIN_W'(655360);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_AMOUNT = 2'd2;

    typedef enum logic [1:0] {
        OP_FIELD_WR = 2'd0,
        OP_PUSH     = 2'd1,
        OP_CHG_RD   = 2'd2
    } t_op;

    typedef struct packed {
        logic [GAIN_W-1:0] accel_gain;
        logic [GAIN_W-1:0] drift_gain;
        logic [GAIN_W-1:0] charge_amount;
    } t_cfg;

    // one classified job, index 0 of each vector is the x component
    typedef struct packed {
        t_op                       op;
        logic [CELL_W-1:0]         cell_idx;
        logic [2:0][FLD_W-1:0]     fld;
        logic [2:0][POS_W-1:0]     pos;
        logic [2:0][SPD_W-1:0]     spd;
    } t_job;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FWR,
        ST_CRD_RD,
        ST_CRD_WR,
        ST_GATHER,
        ST_UPDATE,
        ST_DEPOSIT,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

### hw/rtl/ppd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_if: valid/ready channels of the particle push and deposit engine
// input job channel and result channel
// ----------------------------------------------------------------------------
interface ppd_in_if import ppd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               operation;
    logic [CELL_W-1:0]        cell_index;
    logic signed [FLD_W-1:0]  field_x;
    logic signed [FLD_W-1:0]  field_y;
    logic signed [FLD_W-1:0]  field_z;
    logic [POS_W-1:0]         pos_x;
    logic [POS_W-1:0]         pos_y;
    logic [POS_W-1:0]         pos_z;
    logic signed [SPD_W-1:0]  speed_x;
    logic signed [SPD_W-1:0]  speed_y;
    logic signed [SPD_W-1:0]  speed_z;

    modport source (
        output valid, operation, cell_index, field_x, field_y, field_z,
               pos_x, pos_y, pos_z, speed_x, speed_y, speed_z,
        input  ready
    );
    modport sink (
        input  valid, operation, cell_index, field_x, field_y, field_z,
               pos_x, pos_y, pos_z, speed_x, speed_y, speed_z,
        output ready
    );
endinterface

interface ppd_out_if import ppd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [POS_W-1:0]         new_pos_x;
    logic [POS_W-1:0]         new_pos_y;
    logic [POS_W-1:0]         new_pos_z;
    logic signed [SPD_W-1:0]  new_speed_x;
    logic signed [SPD_W-1:0]  new_speed_y;
    logic signed [SPD_W-1:0]  new_speed_z;
    logic [CELL_W-1:0]        target_cell;
    logic [CHG_W-1:0]         charge_value;

    modport source (
        output valid, new_pos_x, new_pos_y, new_pos_z, new_speed_x, new_speed_y,
               new_speed_z, target_cell, charge_value,
        input  ready
    );
    modport sink (
        input  valid, new_pos_x, new_pos_y, new_pos_z, new_speed_x, new_speed_y,
               new_speed_z, target_cell, charge_value,
        output ready
    );
endinterface
`default_nettype wire

### hw/rtl/pic_particle_push_deposit.sv
`default_nettype none
// a push runs the gather, update, deposit and emit states; a charge read runs the
// charge read, charge write and emit states; a field write retires with no result;
// one job at a time in the back end; a push takes eight corner reads of the field memory,
// an update in accel, speed, drift and position steps, and eight charge read-modify-writes
// reset clears all 262144 charge memory cells in one pass, no input beat taken meanwhile
// ----------------------------------------------------------------------------
// pic_particle_push_deposit: particle-in-cell push and charge deposit engine
// periodic 64 cubed grid, q.16 fixed point, trilinear gather and scatter
// ----------------------------------------------------------------------------
module pic_particle_push_deposit import ppd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    ppd_in_if.sink                     i_in,
    ppd_out_if.source                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [GAIN_W-1:0]     i_cfg_data
);

    // configuration registers
    t_cfg  r_cfg;

    // front to back queue
    logic  job_valid;
    t_job  job;
    logic  job_pop;
    logic  clearing;

    // register writes, an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_gain    <= ACCEL_GAIN_RST;
            r_cfg.drift_gain    <= DRIFT_GAIN_RST;
            r_cfg.charge_amount <= CHARGE_AMOUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACCEL_GAIN:    r_cfg.accel_gain    <= i_cfg_data;
                CFG_DRIFT_GAIN:    r_cfg.drift_gain    <= i_cfg_data;
                CFG_CHARGE_AMOUNT: r_cfg.charge_amount <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // intake: classifies beats and buffers them so the back end can stall alone
    ppd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_clearing  (clearing),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    // sequencer: owns both memories and the result register
    ppd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_clearing  (clearing),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

### hw/rtl/ppd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ppd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]          i_wdata,
    input  wire logic                      i_re,
    input  wire logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/ppd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_front: job intake
// takes input beats, drops unknown operations and queues the rest
// ----------------------------------------------------------------------------
module ppd_front import ppd_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ppd_in_if.sink      i_in,
    input  wire logic   i_clearing,
    output logic        o_job_valid,
    output t_job        o_job,
    input  wire logic   i_job_pop
);

    t_job              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              keep;
    logic              push;
    t_job              job_in;

    assign i_in.ready = !i_clearing && (r_count != QCNT_W'(QUEUE_DEPTH));

    always_comb begin
        unique case (i_in.operation) inside
            OP_FIELD_WR, OP_PUSH, OP_CHG_RD: keep = 1'b1;
            default:                          keep = 1'b0;
        endcase
    end

    assign push = i_in.valid && i_in.ready && keep;

    always_comb begin
        job_in.op       = t_op'(i_in.operation);
        job_in.cell_idx = i_in.cell_index;
        job_in.fld      = {i_in.field_z, i_in.field_y, i_in.field_x};
        job_in.pos      = {i_in.pos_z, i_in.pos_y, i_in.pos_x};
        job_in.spd      = {i_in.speed_z, i_in.speed_y, i_in.speed_x};
    end

    assign o_job_valid = (r_count != '0);
    assign o_job       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_job_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !i_job_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_job_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= job_in;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/ppd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_back: job sequencer
// field and charge memories, corner pipeline, speed and position update
// ----------------------------------------------------------------------------
module ppd_back import ppd_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_job_valid,
    input  wire t_job   i_job,
    output logic        o_job_pop,
    output logic        o_clearing,
    ppd_out_if.source   o_out
);

    localparam int PROD_W = WGT_W + 1 + FLD_W;
    localparam int M_W    = GAIN_W + 1 + FLD_W;
    localparam int SUM_W  = M_W - FRAC_BITS + 1;
    localparam int ADD_W  = GAIN_W + WGT_W - FRAC_BITS;
    localparam int CNT_W  = 4;

    localparam logic [CNT_W-1:0] PIPE_END    = CNT_W'(CORNERS + 2);
    localparam logic [CNT_W-1:0] UPD_ACCEL   = CNT_W'(0);
    localparam logic [CNT_W-1:0] UPD_SPEED   = CNT_W'(1);
    localparam logic [CNT_W-1:0] UPD_DRIFT   = CNT_W'(2);
    localparam logic [CNT_W-1:0] UPD_POS     = CNT_W'(3);
    localparam logic [SPD_W-1:0] SPD_MAX     = {1'b0, {(SPD_W-1){1'b1}}};
    localparam logic [SPD_W-1:0] SPD_MIN     = {1'b1, {(SPD_W-1){1'b0}}};

    function automatic logic [WGT_W-1:0] axis_weight(input logic [FRAC_BITS-1:0] frac,
                                                     input logic hi_side);
        logic [WGT_W-1:0] f;
        f = {1'b0, frac};
        return hi_side ? f : WGT_ONE - f;
    endfunction

    function automatic logic [SPD_W-1:0] sat_speed(input logic [SPD_W-1:0] spd,
                                                   input logic [M_W-1:0] m);
        logic [SUM_W-1:0] t;
        t = {{(SUM_W-SPD_W){spd[SPD_W-1]}}, spd} + {m[M_W-1], m[M_W-1:FRAC_BITS]};
        if (t[SUM_W-1:SPD_W-1] == '0 || t[SUM_W-1:SPD_W-1] == '1) begin
            return t[SPD_W-1:0];
        end
        return t[SUM_W-1] ? SPD_MIN : SPD_MAX;
    endfunction

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [CELL_W-1:0]       r_clr_addr;
    logic [2:0]              r_v;
    logic                    r_out_valid;

    t_job                    r_job;
    logic [2:0][POS_W-1:0]   r_cur;
    logic [2:0][SPD_W-1:0]   r_sp;
    logic [2:0][FLD_W-1:0]   r_e;
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [PROD_W-1:0] r_acc  [3];
    logic signed [M_W-1:0]   r_m    [3];
    logic [WGT_W-1:0]        r_wxy, r_wz, r_w;
    logic [CELL_W-1:0]       r_idx0, r_idx1, r_idx2;
    logic [ADD_W-1:0]        r_add;

    logic [2:0][POS_W-1:0]   r_o_pos;
    logic [2:0][SPD_W-1:0]   r_o_spd;
    logic [CELL_W-1:0]       r_o_cell;
    logic [CHG_W-1:0]        r_o_chg;

    // corner selection
    logic [2:0][AXIS_W-1:0]  coord;
    logic [2:0][WGT_W-1:0]   wsel;
    logic [CELL_W-1:0]       corner_idx;
    logic [2*WGT_W-1:0]      wxy_full;
    logic [2*WGT_W-1:0]      w_full;
    logic [GAIN_W+WGT_W-1:0] add_full;
    logic [CHG_W:0]          csum;
    logic [CHG_W-1:0]        csat;

    // memory ports
    logic                    f_we, f_re;
    logic [CELL_W-1:0]       f_waddr, f_raddr;
    logic [3*FLD_W-1:0]      f_wdata, f_rdata;
    logic                    c_we, c_re;
    logic [CELL_W-1:0]       c_waddr, c_raddr;
    logic [CHG_W-1:0]        c_wdata, c_rdata;

    logic                    issue;
    logic                    emit_go;

    ppd_ram #(.WIDTH(3 * FLD_W), .DEPTH(NCELLS)) u_field_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_re    (f_re),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    ppd_ram #(.WIDTH(CHG_W), .DEPTH(NCELLS)) u_charge_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    always_comb begin
        logic [AXIS_W-1:0] lo;
        logic              b;
        for (int d = 0; d < 3; d++) begin
            b        = r_cnt[2-d];
            lo       = r_cur[d][POS_W-1:FRAC_BITS];
            coord[d] = b ? AXIS_W'(lo + 1'b1) : lo;
            wsel[d]  = axis_weight(r_cur[d][FRAC_BITS-1:0], b);
        end
        corner_idx = {coord[0], coord[1], coord[2]};
    end

    assign wxy_full = wsel[0] * wsel[1];
    assign w_full   = r_wxy * r_wz;
    assign add_full = {{WGT_W{1'b0}}, i_cfg.charge_amount} * {{GAIN_W{1'b0}}, r_w};
    assign csum     = {1'b0, c_rdata} + (CHG_W+1)'(r_add);
    assign csat     = csum[CHG_W] ? '1 : csum[CHG_W-1:0];

    assign issue   = (r_state == ST_GATHER || r_state == ST_DEPOSIT) &&
                     (r_cnt < CNT_W'(CORNERS));
    assign emit_go = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == CELL_W'(NCELLS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_job_valid) begin
                    unique case (i_job.op)
                        OP_FIELD_WR: n_state = ST_FWR;
                        OP_PUSH:     n_state = ST_GATHER;
                        OP_CHG_RD:   n_state = ST_CRD_RD;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FWR:     n_state = ST_IDLE;
            ST_CRD_RD:  n_state = ST_CRD_WR;
            ST_CRD_WR:  n_state = ST_EMIT;
            ST_GATHER: begin
                if (r_cnt == PIPE_END) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (r_cnt == UPD_POS) n_state = ST_DEPOSIT;
            end
            ST_DEPOSIT: begin
                if (r_cnt == PIPE_END) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_go) n_state = ST_IDLE;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_job_pop  = 1'b0;
        o_clearing = 1'b0;
        f_we       = 1'b0;
        f_waddr    = r_job.cell_idx;
        f_wdata    = r_job.fld;
        f_re       = 1'b0;
        f_raddr    = corner_idx;
        c_we       = 1'b0;
        c_waddr    = r_job.cell_idx;
        c_wdata    = '0;
        c_re       = 1'b0;
        c_raddr    = r_job.cell_idx;
        unique case (r_state)
            ST_CLEAR: begin
                o_clearing = 1'b1;
                c_we       = 1'b1;
                c_waddr    = r_clr_addr;
            end
            ST_IDLE:    o_job_pop = i_job_valid;
            ST_FWR:     f_we = 1'b1;
            ST_CRD_RD:  c_re = 1'b1;
            ST_CRD_WR:  c_we = 1'b1;
            ST_GATHER:  f_re = issue;
            ST_DEPOSIT: begin
                c_re    = r_v[1];
                c_raddr = r_idx1;
                c_we    = r_v[2];
                c_waddr = r_idx2;
                c_wdata = csat;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_clr_addr  <= '0;
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= (n_state != r_state) ? '0 : r_cnt + 1'b1;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            r_v        <= {r_v[1:0], issue};
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
            r_cur <= i_job.pos;
            for (int d = 0; d < 3; d++) r_acc[d] <= '0;
        end
        // corner pipeline, shared by gather and deposit
        if (issue) begin
            r_wxy  <= wxy_full[FRAC_BITS +: WGT_W];
            r_wz   <= wsel[2];
            r_idx0 <= corner_idx;
        end
        if (r_v[0]) begin
            r_w    <= w_full[FRAC_BITS +: WGT_W];
            r_idx1 <= r_idx0;
            r_e    <= f_rdata;
        end
        if (r_v[1]) begin
            for (int d = 0; d < 3; d++) begin
                r_prod[d] <= $signed({1'b0, r_w}) * $signed(r_e[d]);
            end
            r_add  <= add_full[FRAC_BITS +: ADD_W];
            r_idx2 <= r_idx1;
        end
        if (r_v[2] && r_state == ST_GATHER) begin
            for (int d = 0; d < 3; d++) r_acc[d] <= r_acc[d] + r_prod[d];
        end
        // speed and position, one lane per axis
        if (r_state == ST_UPDATE) begin
            for (int d = 0; d < 3; d++) begin
                case (r_cnt)
                    UPD_ACCEL: r_m[d] <= $signed({1'b0, i_cfg.accel_gain}) *
                                         $signed(r_acc[d][FRAC_BITS +: FLD_W]);
                    UPD_SPEED: r_sp[d] <= sat_speed(r_job.spd[d], r_m[d]);
                    UPD_DRIFT: r_m[d] <= $signed({1'b0, i_cfg.drift_gain}) *
                                         $signed(r_sp[d]);
                    UPD_POS:   r_cur[d] <= r_cur[d] + r_m[d][FRAC_BITS +: POS_W];
                    default: ;
                endcase
            end
        end
        if (emit_go) begin
            if (r_job.op == OP_PUSH) begin
                r_o_pos  <= r_cur;
                r_o_spd  <= r_sp;
                r_o_cell <= {r_cur[0][POS_W-1:FRAC_BITS], r_cur[1][POS_W-1:FRAC_BITS],
                             r_cur[2][POS_W-1:FRAC_BITS]};
                r_o_chg  <= '0;
            end else begin
                r_o_pos  <= '0;
                r_o_spd  <= '0;
                r_o_cell <= '0;
                r_o_chg  <= c_rdata;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.new_pos_x    = r_o_pos[0];
    assign o_out.new_pos_y    = r_o_pos[1];
    assign o_out.new_pos_z    = r_o_pos[2];
    assign o_out.new_speed_x  = r_o_spd[0];
    assign o_out.new_speed_y  = r_o_spd[1];
    assign o_out.new_speed_z  = r_o_spd[2];
    assign o_out.target_cell  = r_o_cell;
    assign o_out.charge_value = r_o_chg;

endmodule
`default_nettype wire

### sim/pic_particle_push_deposit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pic_particle_push_deposit_tb: self-checking bench of the push and deposit engine
// drives field writes, particle pushes and charge reads with random gaps and
// back-pressure, predicts every result beat in a bit-true model and compares
// ----------------------------------------------------------------------------
module pic_particle_push_deposit_tb;
    import ppd_pkg::*;

    localparam logic [1:0] OP_RESERVED   = 2'd3;
    localparam longint     CYCLE_LIMIT   = 2_000_000;
    localparam int         SETTLE_CYCLES = 40;        // beyond the longest job latency
    localparam int         HOLD_CYCLES   = 2500;
    localparam longint     CHG_SAT       = (longint'(1) << CHG_W) - 1;
    localparam longint     PERIOD        = longint'(GRID_SIZE) << FRAC_BITS;
    localparam longint     ONE           = longint'(1) << FRAC_BITS;

    // one input beat
    typedef struct {
        logic [1:0]                op;
        logic [CELL_W-1:0]         cell_idx;
        logic [2:0][FLD_W-1:0]     fld;
        logic [2:0][POS_W-1:0]     pos;
        logic [2:0][SPD_W-1:0]     spd;
    } job_t;

    // one result beat
    typedef struct {
        logic [2:0][POS_W-1:0]     pos;
        logic [2:0][SPD_W-1:0]     spd;
        logic [CELL_W-1:0]         cell_idx;
        logic [CHG_W-1:0]          chg;
    } outcome_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [GAIN_W-1:0]     i_cfg_data = '0;

    ppd_in_if  in_ch ();
    ppd_out_if out_ch ();

    pic_particle_push_deposit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the block: field vectors per written cell, charge accumulators
    logic [2:0][FLD_W-1:0] field_mem [int];
    longint                charge_mem [int];
    t_cfg                  gains;
    outcome_t              pending_results [$];
    int                    recent_targets [$];
    int                    corner_idx [8];
    longint                corner_wgt [8];

    int     mismatches = 0;
    longint cycles = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_seq = 0;
    int     hold_seen = 0;
    int     hold_left = 0;

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // corner cells and trilinear weights of a position, wrapping at the grid edge
    function automatic void find_corners(input logic [2:0][POS_W-1:0] p);
        int     lo [3];
        int     hi [3];
        longint r [3];
        longint c [3];
        longint wa, wb, wc;
        int     d, k;
        for (d = 0; d < 3; d++) begin
            lo[d] = int'(p[d][POS_W-1:FRAC_BITS]);
            hi[d] = (lo[d] + 1) % GRID_SIZE;
            r[d]  = longint'(p[d][FRAC_BITS-1:0]);
            c[d]  = ONE - r[d];
        end
        for (k = 0; k < 8; k++) begin
            wa = k[2] ? r[0] : c[0];
            wb = k[1] ? r[1] : c[1];
            wc = k[0] ? r[2] : c[2];
            corner_idx[k] = ((k[2] ? hi[0] : lo[0]) * GRID_SIZE + (k[1] ? hi[1] : lo[1]))
                            * GRID_SIZE + (k[0] ? hi[2] : lo[2]);
            corner_wgt[k] = (((wa * wb) >> FRAC_BITS) * wc) >> FRAC_BITS;
        end
    endfunction

    // gather, update speed and position, then scatter the charge
    function automatic outcome_t push_particle(input job_t j);
        outcome_t              o;
        logic [2:0][POS_W-1:0] np;
        longint                acc, fld, sp, pp, add, s;
        int                    d, k;
        o = '{default: '0};
        find_corners(j.pos);
        for (d = 0; d < 3; d++) begin
            acc = 0;
            for (k = 0; k < 8; k++)
                acc += corner_wgt[k] * longint'($signed(field_mem[corner_idx[k]][d]));
            fld = acc >>> FRAC_BITS;
            sp  = longint'($signed(j.spd[d]))
                  + ((longint'(gains.accel_gain) * fld) >>> FRAC_BITS);
            if (sp > 64'sd2147483647) sp = 64'sd2147483647;
            if (sp < -64'sd2147483648) sp = -64'sd2147483648;
            pp = longint'(j.pos[d]) + ((longint'(gains.drift_gain) * sp) >>> FRAC_BITS);
            pp = pp % PERIOD;
            if (pp < 0) pp += PERIOD;
            np[d]    = pp[POS_W-1:0];
            o.pos[d] = np[d];
            o.spd[d] = sp[SPD_W-1:0];
        end
        o.cell_idx = {np[0][POS_W-1:FRAC_BITS], np[1][POS_W-1:FRAC_BITS],
                      np[2][POS_W-1:FRAC_BITS]};
        find_corners(np);
        for (k = 0; k < 8; k++) begin
            add = (longint'(gains.charge_amount) * corner_wgt[k]) >> FRAC_BITS;
            s   = (charge_mem.exists(corner_idx[k]) ? charge_mem[corner_idx[k]] : 0) + add;
            charge_mem[corner_idx[k]] = (s > CHG_SAT) ? CHG_SAT : s;
        end
        recent_targets.push_back(int'(o.cell_idx));
        if (recent_targets.size() > 16) void'(recent_targets.pop_front());
        return o;
    endfunction

    // apply one accepted beat to the shadow and queue its result, if any
    function automatic void apply_job(input job_t j);
        outcome_t o;
        o = '{default: '0};
        case (j.op)
            OP_FIELD_WR: begin
                field_mem[int'(j.cell_idx)] = j.fld;
            end
            OP_PUSH: begin
                pending_results.push_back(push_particle(j));
            end
            OP_CHG_RD: begin
                if (charge_mem.exists(int'(j.cell_idx)))
                    o.chg = charge_mem[int'(j.cell_idx)][CHG_W-1:0];
                charge_mem.delete(int'(j.cell_idx));
                pending_results.push_back(o);
            end
            default: begin
                // reserved code, dropped by the block
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic note_mismatch(input string what, input longint exp_v, input longint act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h actual %h at cycle %0d",
                     what, exp_v, act_v, cycles);
    endtask

    // compare each result beat against the oldest prediction
    always @(posedge i_clk) begin
        outcome_t e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected beat", 0, longint'(out_ch.charge_value));
            end else begin
                e = pending_results.pop_front();
                if (e.pos[0] !== out_ch.new_pos_x) note_mismatch("new_pos_x", e.pos[0], out_ch.new_pos_x);
                if (e.pos[1] !== out_ch.new_pos_y) note_mismatch("new_pos_y", e.pos[1], out_ch.new_pos_y);
                if (e.pos[2] !== out_ch.new_pos_z) note_mismatch("new_pos_z", e.pos[2], out_ch.new_pos_z);
                if (e.spd[0] !== out_ch.new_speed_x)
                    note_mismatch("new_speed_x", e.spd[0], out_ch.new_speed_x);
                if (e.spd[1] !== out_ch.new_speed_y)
                    note_mismatch("new_speed_y", e.spd[1], out_ch.new_speed_y);
                if (e.spd[2] !== out_ch.new_speed_z)
                    note_mismatch("new_speed_z", e.spd[2], out_ch.new_speed_z);
                if (e.cell_idx !== out_ch.target_cell)
                    note_mismatch("target_cell", e.cell_idx, out_ch.target_cell);
                if (e.chg !== out_ch.charge_value)
                    note_mismatch("charge_value", e.chg, out_ch.charge_value);
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offer one beat, hold it until taken, then maybe go idle for a while
    task automatic send_job(input job_t j);
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= j.op;
        in_ch.cell_index <= j.cell_idx;
        in_ch.field_x    <= j.fld[0];
        in_ch.field_y    <= j.fld[1];
        in_ch.field_z    <= j.fld[2];
        in_ch.pos_x      <= j.pos[0];
        in_ch.pos_y      <= j.pos[1];
        in_ch.pos_z      <= j.pos[2];
        in_ch.speed_x    <= j.spd[0];
        in_ch.speed_y    <= j.spd[1];
        in_ch.speed_z    <= j.spd[2];
        do @(posedge i_clk); while (!in_ch.ready);
        apply_job(j);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // stop offering, let every predicted beat arrive, then let the back end settle
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ACCEL_GAIN:    gains.accel_gain = val;
            CFG_DRIFT_GAIN:    gains.drift_gain = val;
            CFG_CHARGE_AMOUNT: gains.charge_amount = val;
            default: ;
        endcase
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] ag, input logic [GAIN_W-1:0] dg,
                             input logic [GAIN_W-1:0] ca);
        wait_drained();
        write_gain(CFG_ACCEL_GAIN, ag);
        write_gain(CFG_DRIFT_GAIN, dg);
        write_gain(CFG_CHARGE_AMOUNT, ca);
    endtask

    // field values lean on the extremes and on small magnitudes
    function automatic logic [31:0] rand_word(input int small_span);
        case ($urandom_range(9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3, 4: return 32'($signed($urandom_range(2 * small_span)) - small_span);
            default: return $urandom;
        endcase
    endfunction

    // particles start in cells with integer part 63 or 0 on each axis, where the
    // field is loaded at every corner, including the wrapped ones
    function automatic logic [POS_W-1:0] rand_axis();
        return {($urandom_range(1) ? 6'd63 : 6'd0), 16'($urandom)};
    endfunction

    function automatic logic [CELL_W-1:0] loaded_cell();
        int x, y, z;
        x = ($urandom_range(2) + 63) % GRID_SIZE;
        y = ($urandom_range(2) + 63) % GRID_SIZE;
        z = ($urandom_range(2) + 63) % GRID_SIZE;
        return CELL_W'((x * GRID_SIZE + y) * GRID_SIZE + z);
    endfunction

    // a recent target cell or one of its upper neighbours, where charge sits
    function automatic logic [CELL_W-1:0] charged_cell();
        logic [CELL_W-1:0] t;
        t = CELL_W'(recent_targets[$urandom_range(recent_targets.size() - 1)]);
        return {t[17:12] + 6'($urandom_range(1)), t[11:6] + 6'($urandom_range(1)),
                t[5:0] + 6'($urandom_range(1))};
    endfunction

    function automatic job_t random_job();
        job_t j;
        int   d, pick;
        j.op       = OP_PUSH;
        j.cell_idx = CELL_W'($urandom);
        for (d = 0; d < 3; d++) begin
            j.fld[d] = rand_word(4 << FRAC_BITS);
            j.pos[d] = rand_axis();
            j.spd[d] = rand_word(8 << FRAC_BITS);
        end
        pick = $urandom_range(99);
        if (pick < 15) begin
            j.op = OP_FIELD_WR;
            if ($urandom_range(9) < 7) j.cell_idx = loaded_cell();
        end else if (pick < 40) begin
            j.op = OP_CHG_RD;
            if (recent_targets.size() > 0 && $urandom_range(9) < 7) j.cell_idx = charged_cell();
        end else if (pick < 45) begin
            j.op = OP_RESERVED;
        end
        return j;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // field over the 27 cells around the wrapped corner of the grid
    task automatic test_field_load();
        job_t j;
        int   x, y, z, d;
        j = random_job();
        j.op = OP_FIELD_WR;
        for (x = 0; x < 3; x++)
            for (y = 0; y < 3; y++)
                for (z = 0; z < 3; z++) begin
                    j.cell_idx = CELL_W'((((x + 63) % GRID_SIZE) * GRID_SIZE
                                  + (y + 63) % GRID_SIZE) * GRID_SIZE + (z + 63) % GRID_SIZE);
                    for (d = 0; d < 3; d++) j.fld[d] = rand_word(4 << FRAC_BITS);
                    send_job(j);
                end
    endtask

    task automatic test_directed();
        job_t j;
        int   d;
        j = random_job();
        // reserved code gives nothing back
        j.op = OP_RESERVED;
        send_job(j);
        // extreme field at the origin cell
        j.op = OP_FIELD_WR;
        j.cell_idx = '0;
        j.fld = {3{32'h7fff_ffff}};
        send_job(j);
        // particle at the very origin at rest
        j.op = OP_PUSH;
        j.pos = '0;
        j.spd = '0;
        send_job(j);
        // largest position, wraps on every axis, speeds at both limits
        j.pos = {3{{6'd63, 16'hffff}}};
        j.spd = {3{32'h7fff_ffff}};
        send_job(j);
        j.spd = {3{32'h8000_0000}};
        send_job(j);
        // opposite field extreme, then speed pushed over the top
        j.op = OP_FIELD_WR;
        j.fld = {3{32'h8000_0000}};
        send_job(j);
        j.op = OP_PUSH;
        j.pos = {3{{6'd63, 16'h8000}}};
        send_job(j);
        j.fld = {3{32'h7fff_ffff}};
        j.op = OP_FIELD_WR;
        send_job(j);
        j.op = OP_PUSH;
        j.spd = {3{32'h7fff_ffff}};
        send_job(j);
        // fraction exactly one half, exactly zero and just under one on the three axes
        j.pos = {{6'd0, 16'h8000}, {6'd63, 16'h0000}, {6'd0, 16'hffff}};
        j.spd = {32'h0001_0000, 32'hffff_0000, 32'h0000_0001};
        send_job(j);
        // read out the deposits twice, the second read sees them cleared
        for (d = 0; d < 4; d++) begin
            j.op = OP_CHG_RD;
            j.cell_idx = CELL_W'(recent_targets[recent_targets.size() - 1 - d]);
            send_job(j);
            send_job(j);
        end
        // never touched cell, top index
        j.cell_idx = '1;
        send_job(j);
        j.op = OP_RESERVED;
        send_job(j);
    endtask

    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        job_t j;
        int   done;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < n) begin
            j = random_job();
            if (j.op != OP_RESERVED) done++;
            send_job(j);
        end
    endtask

    // result side held off while pushes keep coming, then a full pause
    task automatic test_backpressure();
        job_t j;
        int   k;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_seq++;
        for (k = 0; k < 40; k++) begin
            j = random_job();
            j.op = OP_PUSH;
            send_job(j);
        end
        wait_drained();
        test_random(20, 0, 0);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        in_ch.valid      = 1'b0;
        in_ch.operation  = '0;
        in_ch.cell_index = '0;
        in_ch.field_x    = '0;
        in_ch.field_y    = '0;
        in_ch.field_z    = '0;
        in_ch.pos_x      = '0;
        in_ch.pos_y      = '0;
        in_ch.pos_z      = '0;
        in_ch.speed_x    = '0;
        in_ch.speed_y    = '0;
        in_ch.speed_z    = '0;
        out_ch.ready     = 1'b0;
        gains = '{accel_gain: ACCEL_GAIN_RST, drift_gain: DRIFT_GAIN_RST,
                  charge_amount: CHARGE_AMOUNT_RST};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset gains first, inputs wait out the clearing pass on ready
        test_field_load();
        test_directed();
        test_random(400, 0, 0);

        set_gains('1, '1, '1);
        test_random(150, 78, 0);

        set_gains('0, '0, '0);
        test_random(150, 0, 78);

        set_gains(GAIN_W'($urandom_range(65536 * 2)), GAIN_W'($urandom_range(65536 * 2)),
                  GAIN_W'($urandom));
        test_random(400, 14, 14);
        test_backpressure();

        set_gains(ACCEL_GAIN_RST, DRIFT_GAIN_RST, CHARGE_AMOUNT_RST);
        test_random(500, 0, 0);

        wait_drained();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
